// ----- rtl/core/ttf_pkg.sv -----
// Shared types, codes and constants of the triangle tangent frame block.
package ttf_pkg;

	// Output fixed-point format and internal arithmetic sizes
	localparam int UNIT_FRAC_BITS = 14;
	localparam int FIT_BITS       = 30;
	localparam int NUM_W          = UNIT_FRAC_BITS + FIT_BITS + 1;
	localparam int SQRT_STEPS     = 32;
	localparam int ITER_CNT_W     = 7;

	// One vertex item
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vtx_t;

	// One frame item
	typedef struct packed {
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic signed [15:0] binormal_x;
		logic signed [15:0] binormal_y;
		logic signed [15:0] binormal_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               degenerate;
	} frame_t;

	// Multiplier operand pairs
	localparam logic [3:0] MS_DET_A = 4'd0;
	localparam logic [3:0] MS_DET_B = 4'd1;
	localparam logic [3:0] MS_T_A   = 4'd2;
	localparam logic [3:0] MS_T_B   = 4'd3;
	localparam logic [3:0] MS_B_A   = 4'd4;
	localparam logic [3:0] MS_B_B   = 4'd5;
	localparam logic [3:0] MS_SQ    = 4'd6;
	localparam logic [3:0] MS_N_A   = 4'd7;
	localparam logic [3:0] MS_N_B   = 4'd8;

	// Accumulator modes
	localparam logic [1:0] ACC_LOAD = 2'd0;
	localparam logic [1:0] ACC_ADD  = 2'd1;
	localparam logic [1:0] ACC_SUB  = 2'd2;

	// Work phases: determinant, tangent, binormal, normal
	localparam logic [1:0] PH_DET = 2'd0;
	localparam logic [1:0] PH_T   = 2'd1;
	localparam logic [1:0] PH_B   = 2'd2;
	localparam logic [1:0] PH_N   = 2'd3;

	localparam logic [15:0] UNIT_MAX = 16'h7FFF;

	// Controller to datapath commands
	typedef struct packed {
		logic       hold;
		logic       hold_k;
		logic       load_tri;
		logic       mul_en;
		logic [3:0] mul_sel;
		logic [1:0] acc_mode;
		logic [1:0] idx;
		logic [1:0] phase;
		logic       det_latch;
		logic       vec_wr;
		logic       vec_det;
		logic       shift1;
		logic       iter_start;
		logic       iter_sqrt;
		logic       len_load;
		logic       res_wr;
		logic       out_load;
		logic       out_degen;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic det_zero;
		logic fit_ok;
		logic iter_done;
		logic iter_zero;
	} sts_t;

endpackage

// ----- rtl/core/ttf_if.sv -----
// Valid/ready channel interfaces for vertex and frame items.
interface ttf_vtx_if;
	logic             valid;
	logic             ready;
	ttf_pkg::vtx_t    item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ttf_frame_if;
	logic             valid;
	logic             ready;
	ttf_pkg::frame_t  item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/core/ttf_iter.sv -----
// Shared bit-serial unit: integer square root or restoring divide.
module ttf_iter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sqrt_mode,
	input  logic [63:0] op_a,
	input  logic [31:0] op_b,
	output logic        done,
	output logic [63:0] res
);
	import ttf_pkg::*;

	logic                  busy_q;
	logic                  mode_q;
	logic [ITER_CNT_W-1:0] cnt_q;
	logic [63:0]           x_q, r_q, b_q;
	logic [63:0]           x_d, r_d, b_d;
	logic [63:0]           t_sum, rem_n;
	logic                  ge;

	// One step of the selected algorithm
	always_comb begin
		t_sum = r_q + b_q;
		rem_n = {r_q[62:0], x_q[NUM_W-1]};
		ge    = 1'b0;
		x_d   = x_q;
		r_d   = r_q;
		b_d   = b_q;
		if (mode_q) begin
			ge  = (x_q >= t_sum);
			x_d = ge ? (x_q - t_sum) : x_q;
			r_d = ge ? ((r_q >> 1) + b_q) : (r_q >> 1);
			b_d = b_q >> 2;
		end else begin
			ge  = (rem_n >= b_q);
			r_d = ge ? (rem_n - b_q) : rem_n;
			x_d = {x_q[62:0], ge};
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			mode_q <= sqrt_mode;
			cnt_q  <= sqrt_mode ? ITER_CNT_W'(SQRT_STEPS) : ITER_CNT_W'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= op_a;
			r_q <= '0;
			b_q <= sqrt_mode ? (64'd1 << 62) : {32'd0, op_b};
		end else if (busy_q && (cnt_q != '0)) begin
			x_q <= x_d;
			r_q <= r_d;
			b_q <= b_d;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign res  = mode_q ? r_q : {{(64-NUM_W){1'b0}}, x_q[NUM_W-1:0]};

endmodule

// ----- rtl/core/ttf_dp.sv -----
// Datapath: held corners, deltas, multiply-accumulate, vector normalization.
module ttf_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ttf_pkg::cmd_t   cmd,
	output ttf_pkg::sts_t   sts,
	input  ttf_pkg::vtx_t   in_item,
	output ttf_pkg::frame_t out_item
);
	import ttf_pkg::*;

	function automatic logic [1:0] nxt3(logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : (i + 2'd1);
	endfunction

	// Shift amount that brings a 33-bit magnitude below 2^30
	function automatic logic [1:0] fit33(logic [32:0] m);
		logic [1:0] s;
		if (m[32])      s = 2'd3;
		else if (m[31]) s = 2'd2;
		else if (m[30]) s = 2'd1;
		else            s = 2'd0;
		return s;
	endfunction

	function automatic logic [32:0] mag33(logic signed [32:0] v);
		return v[32] ? (33'd0 - v) : v;
	endfunction

	// Shift toward zero into 31 bits
	function automatic logic signed [30:0] shr33(logic signed [32:0] v, logic [1:0] s);
		logic [32:0] m;
		m = mag33(v) >> s;
		return v[32] ? (31'd0 - m[30:0]) : m[30:0];
	endfunction

	logic signed [31:0] p0_q [3];
	logic signed [31:0] p1_q [3];
	logic signed [31:0] t0_q [2];
	logic signed [31:0] t1_q [2];
	logic signed [30:0] e1_q [3];
	logic signed [30:0] e2_q [3];
	logic signed [30:0] tx_q [4];
	logic [62:0]        mag_q [3];
	logic               sgn_q [3];
	logic signed [15:0] ut_q [3];
	logic signed [15:0] ub_q [3];
	logic signed [15:0] un_q [3];
	logic signed [63:0] acc_q, prod_s1;
	logic [1:0]         accop_s1;
	logic               mulv_s1;
	logic               detneg_q;
	logic [31:0]        len_q;
	frame_t             out_q;

	logic signed [31:0] ip [3];
	logic signed [32:0] pd [6];
	logic signed [32:0] td [4];
	logic [32:0]        por, tor;
	logic [1:0]         sp, st;
	logic [1:0]         i1, i2;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic [63:0]        absacc, numer, iter_a, iter_res;
	logic [62:0]        mor;
	logic [15:0]        sat;
	logic signed [15:0] sval;
	logic               iter_done;

	// Edge and texture deltas with shared fitting shifts
	always_comb begin
		ip[0] = in_item.pos_x;
		ip[1] = in_item.pos_y;
		ip[2] = in_item.pos_z;
		por = '0;
		for (int i = 0; i < 3; i++) begin
			pd[i]   = {p1_q[i][31], p1_q[i]} - {p0_q[i][31], p0_q[i]};
			pd[3+i] = {ip[i][31], ip[i]} - {p0_q[i][31], p0_q[i]};
		end
		for (int i = 0; i < 6; i++) begin
			por = por | mag33(pd[i]);
		end
		td[0] = {t1_q[0][31], t1_q[0]} - {t0_q[0][31], t0_q[0]};
		td[1] = {t1_q[1][31], t1_q[1]} - {t0_q[1][31], t0_q[1]};
		td[2] = {in_item.tex_u[31], in_item.tex_u} - {t0_q[0][31], t0_q[0]};
		td[3] = {in_item.tex_v[31], in_item.tex_v} - {t0_q[1][31], t0_q[1]};
		tor = '0;
		for (int i = 0; i < 4; i++) begin
			tor = tor | mag33(td[i]);
		end
		sp = fit33(por);
		st = fit33(tor);
	end

	// Multiplier operand selection
	always_comb begin
		i1 = nxt3(cmd.idx);
		i2 = nxt3(i1);
		ma = '0;
		mb = '0;
		unique case (cmd.mul_sel)
			MS_DET_A: begin ma = {tx_q[0][30], tx_q[0]}; mb = {tx_q[3][30], tx_q[3]}; end
			MS_DET_B: begin ma = {tx_q[2][30], tx_q[2]}; mb = {tx_q[1][30], tx_q[1]}; end
			MS_T_A: begin
				ma = {tx_q[3][30], tx_q[3]};
				mb = {e1_q[cmd.idx][30], e1_q[cmd.idx]};
			end
			MS_T_B: begin
				ma = {tx_q[1][30], tx_q[1]};
				mb = {e2_q[cmd.idx][30], e2_q[cmd.idx]};
			end
			MS_B_A: begin
				ma = {tx_q[0][30], tx_q[0]};
				mb = {e2_q[cmd.idx][30], e2_q[cmd.idx]};
			end
			MS_B_B: begin
				ma = {tx_q[2][30], tx_q[2]};
				mb = {e1_q[cmd.idx][30], e1_q[cmd.idx]};
			end
			MS_SQ: begin
				ma = {2'b00, mag_q[cmd.idx][FIT_BITS-1:0]};
				mb = {2'b00, mag_q[cmd.idx][FIT_BITS-1:0]};
			end
			MS_N_A: begin
				ma = {{16{ut_q[i1][15]}}, ut_q[i1]};
				mb = {{16{ub_q[i2][15]}}, ub_q[i2]};
			end
			MS_N_B: begin
				ma = {{16{ut_q[i2][15]}}, ut_q[i2]};
				mb = {{16{ub_q[i1][15]}}, ub_q[i1]};
			end
			default: begin ma = '0; mb = '0; end
		endcase
		mp = ma * mb;
	end

	// Magnitude, divider numerator and saturated unit component
	always_comb begin
		absacc = acc_q[63] ? (64'd0 - acc_q) : acc_q;
		mor    = mag_q[0] | mag_q[1] | mag_q[2];
		numer  = {{(64-FIT_BITS-UNIT_FRAC_BITS){1'b0}}, mag_q[cmd.idx][FIT_BITS-1:0],
			{UNIT_FRAC_BITS{1'b0}}} + {33'd0, len_q[31:1]};
		iter_a = cmd.iter_sqrt ? acc_q : numer;
		sat    = (|iter_res[63:15]) ? UNIT_MAX : {1'b0, iter_res[14:0]};
		sval   = sgn_q[cmd.idx] ? (16'd0 - sat) : sat;
	end

	ttf_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.iter_start),
		.sqrt_mode (cmd.iter_sqrt),
		.op_a      (iter_a),
		.op_b      (len_q),
		.done      (iter_done),
		.res       (iter_res)
	);

	// Product pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mulv_s1 <= 1'b0;
		end else begin
			mulv_s1 <= cmd.mul_en;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			if (cmd.hold_k) begin
				for (int i = 0; i < 3; i++) p1_q[i] <= ip[i];
				t1_q[0] <= in_item.tex_u;
				t1_q[1] <= in_item.tex_v;
			end else begin
				for (int i = 0; i < 3; i++) p0_q[i] <= ip[i];
				t0_q[0] <= in_item.tex_u;
				t0_q[1] <= in_item.tex_v;
			end
		end
		if (cmd.load_tri) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= shr33(pd[i], sp);
				e2_q[i] <= shr33(pd[3+i], sp);
			end
			for (int i = 0; i < 4; i++) tx_q[i] <= shr33(td[i], st);
		end
		prod_s1  <= mp;
		accop_s1 <= cmd.acc_mode;
		if (mulv_s1) begin
			unique case (accop_s1)
				ACC_LOAD: acc_q <= prod_s1;
				ACC_ADD:  acc_q <= acc_q + prod_s1;
				ACC_SUB:  acc_q <= acc_q - prod_s1;
				default:  acc_q <= acc_q;
			endcase
		end
		if (cmd.det_latch) detneg_q <= acc_q[63];
		if (cmd.vec_wr) begin
			mag_q[cmd.idx] <= absacc[62:0];
			sgn_q[cmd.idx] <= acc_q[63] ^ (cmd.vec_det & detneg_q);
		end else if (cmd.shift1) begin
			for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
		end
		if (cmd.len_load) len_q <= iter_res[31:0];
		if (cmd.res_wr) begin
			unique case (cmd.phase)
				PH_T:    ut_q[cmd.idx] <= sval;
				PH_B:    ub_q[cmd.idx] <= sval;
				PH_N:    un_q[cmd.idx] <= sval;
				default: ut_q[cmd.idx] <= ut_q[cmd.idx];
			endcase
		end
		if (cmd.out_load) begin
			if (cmd.out_degen) begin
				// all vectors zero, degenerate flag (lowest bit) set
				out_q <= {144'd0, 1'b1};
			end else begin
				out_q.tangent_x  <= ut_q[0];
				out_q.tangent_y  <= ut_q[1];
				out_q.tangent_z  <= ut_q[2];
				out_q.binormal_x <= ub_q[0];
				out_q.binormal_y <= ub_q[1];
				out_q.binormal_z <= ub_q[2];
				out_q.normal_x   <= un_q[0];
				out_q.normal_y   <= un_q[1];
				out_q.normal_z   <= un_q[2];
				out_q.degenerate <= 1'b0;
			end
		end
	end

	// Status to the controller
	always_comb begin
		sts.det_zero  = (acc_q == '0);
		sts.fit_ok    = ~|mor[62:FIT_BITS];
		sts.iter_done = iter_done;
		sts.iter_zero = (iter_res == '0);
	end

	assign out_item = out_q;

endmodule

// ----- rtl/core/ttf_ctrl.sv -----
// Controller: corner counting, item handshakes and the per-triangle sequence.
module ttf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ttf_pkg::cmd_t cmd,
	input  ttf_pkg::sts_t sts
);
	import ttf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MA   = 4'd1;
	localparam logic [3:0] S_MB   = 4'd2;
	localparam logic [3:0] S_MW   = 4'd3;
	localparam logic [3:0] S_MR   = 4'd4;
	localparam logic [3:0] S_FIT  = 4'd5;
	localparam logic [3:0] S_SQ   = 4'd6;
	localparam logic [3:0] S_SQW  = 4'd7;
	localparam logic [3:0] S_RT   = 4'd8;
	localparam logic [3:0] S_RTW  = 4'd9;
	localparam logic [3:0] S_DV   = 4'd10;
	localparam logic [3:0] S_DVW  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [1:0] idx_q, idx_d;
	logic [1:0] corner_q, corner_d;
	logic       degen_q, degen_d;
	logic       out_valid_q, out_valid_d;
	logic [3:0] sel_a, sel_b;

	// Operand pairs of the current phase
	always_comb begin
		unique case (phase_q)
			PH_DET: begin sel_a = MS_DET_A; sel_b = MS_DET_B; end
			PH_T:   begin sel_a = MS_T_A;   sel_b = MS_T_B;   end
			PH_B:   begin sel_a = MS_B_A;   sel_b = MS_B_B;   end
			PH_N:   begin sel_a = MS_N_A;   sel_b = MS_N_B;   end
			default: begin sel_a = MS_DET_A; sel_b = MS_DET_B; end
		endcase
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		idx_d       = idx_q;
		corner_d    = corner_q;
		degen_d     = degen_q;
		out_valid_d = out_valid_q & ~out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.idx     = idx_q;
		cmd.phase   = phase_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (corner_q < 2'd2) begin
						cmd.hold   = 1'b1;
						cmd.hold_k = corner_q[0];
						corner_d   = corner_q + 2'd1;
					end else begin
						cmd.load_tri = 1'b1;
						corner_d     = 2'd0;
						phase_d      = PH_DET;
						idx_d        = 2'd0;
						degen_d      = 1'b0;
						state_d      = S_MA;
					end
				end
			end
			S_MA: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = sel_a;
				cmd.acc_mode = ACC_LOAD;
				state_d      = S_MB;
			end
			S_MB: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = sel_b;
				cmd.acc_mode = ACC_SUB;
				state_d      = S_MW;
			end
			S_MW: state_d = S_MR;
			S_MR: begin
				if (phase_q == PH_DET) begin
					cmd.det_latch = 1'b1;
					if (sts.det_zero) begin
						degen_d = 1'b1;
						state_d = S_OUT;
					end else begin
						phase_d = PH_T;
						state_d = S_MA;
					end
				end else begin
					cmd.vec_wr  = 1'b1;
					cmd.vec_det = (phase_q != PH_N);
					if (idx_q == 2'd2) begin
						idx_d   = 2'd0;
						state_d = S_FIT;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = S_MA;
					end
				end
			end
			// Shift the vector down until every magnitude fits
			S_FIT: begin
				if (sts.fit_ok) begin
					idx_d   = 2'd0;
					state_d = S_SQ;
				end else begin
					cmd.shift1 = 1'b1;
				end
			end
			S_SQ: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_SQ;
				cmd.acc_mode = (idx_q == 2'd0) ? ACC_LOAD : ACC_ADD;
				if (idx_q == 2'd2) begin
					idx_d   = 2'd0;
					state_d = S_SQW;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			S_SQW: state_d = S_RT;
			S_RT: begin
				cmd.iter_start = 1'b1;
				cmd.iter_sqrt  = 1'b1;
				state_d        = S_RTW;
			end
			S_RTW: begin
				cmd.iter_sqrt = 1'b1;
				if (sts.iter_done) begin
					cmd.len_load = 1'b1;
					if (sts.iter_zero) begin
						degen_d = 1'b1;
						state_d = S_OUT;
					end else begin
						idx_d   = 2'd0;
						state_d = S_DV;
					end
				end
			end
			S_DV: begin
				cmd.iter_start = 1'b1;
				state_d        = S_DVW;
			end
			S_DVW: begin
				if (sts.iter_done) begin
					cmd.res_wr = 1'b1;
					if (idx_q == 2'd2) begin
						idx_d = 2'd0;
						unique case (phase_q)
							PH_T: begin phase_d = PH_B; state_d = S_MA; end
							PH_B: begin phase_d = PH_N; state_d = S_MA; end
							default: state_d = S_OUT;
						endcase
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = S_DV;
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load  = 1'b1;
					cmd.out_degen = degen_q;
					out_valid_d   = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_DET;
			idx_q       <= 2'd0;
			corner_q    <= 2'd0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			idx_q       <= idx_d;
			corner_q    <= corner_d;
			degen_q     <= degen_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/triangle_tangent_frame.sv -----
// Per-triangle tangent, binormal and normal unit vectors from a vertex stream.
// First and second vertex of a triangle: accepted and held.
// Third vertex: starts the sequence of determinant, tangent, binormal and normal that ends in the frame
// item; each vector is shifted down to fit before the shared bit-serial root/divide unit takes its
// length and divides each component by it. Degenerate triangles finish earlier.
// One triangle is worked on at a time; no vertex is accepted meanwhile.
// Reset clears the corner count, the sequencer and the output valid; held data is not.
module triangle_tangent_frame (
	input  logic        clk,
	input  logic        arst_n,
	ttf_vtx_if.sink     vtx,
	ttf_frame_if.source frame
);
	import ttf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ttf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx.valid),
		.in_ready  (vtx.ready),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ttf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_item  (vtx.item),
		.out_item (frame.item)
	);

endmodule

// ----- bench/tb_frame_checker.sv -----
// Frame checker: watches the vertex and frame channels, computes expected frames and compares.
`timescale 1ns / 100ps
module tb_frame_checker (
	input  logic     clk,
	input  logic     arst_n,
	ttf_vtx_if       vtx,
	ttf_frame_if     frame,
	output int       fail_count,
	output int       pending,
	output int       frames_seen,
	output int       degen_seen
);
	import ttf_pkg::*;

	localparam int UNIT_BITS = 14;
	localparam int FIT_W     = 30;
	localparam int EXP_DEPTH = 1024;

	// Predictor state
	logic [1:0]         corner_cnt;
	logic signed [63:0] held_pos [6];
	logic signed [63:0] held_tex [4];
	frame_t             exp_mem [EXP_DEPTH];
	int                 exp_wr, exp_rd;

	function automatic logic [63:0] magnitude(input logic signed [63:0] x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] shift_toward_zero(input logic signed [63:0] x,
			input int s);
		logic [63:0] m;
		m = magnitude(x) >> s;
		return (x < 0) ? -$signed(m) : $signed(m);
	endfunction

	function automatic int fit_amount(input logic [63:0] acc);
		int s;
		s = 0;
		while ((acc >> s) >= (64'd1 << FIT_W))
			s++;
		return s;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scale a vector to unit length in Q2.14; returns 0 on zero length
	function automatic bit unitize(input logic signed [63:0] v [3],
			output logic signed [15:0] u [3]);
		logic signed [63:0] c [3];
		logic [63:0]        sum, len, q;
		int                 s;
		s = fit_amount(magnitude(v[0]) | magnitude(v[1]) | magnitude(v[2]));
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = shift_toward_zero(v[i], s);
			sum += magnitude(c[i]) * magnitude(c[i]);
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++)
			u[i] = '0;
		if (len == 0)
			return 0;
		for (int i = 0; i < 3; i++) begin
			q = ((magnitude(c[i]) << UNIT_BITS) + len / 2) / len;
			if (q > 64'd32767)
				q = 64'd32767;
			u[i] = (c[i] < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
		end
		return 1;
	endfunction

	// Frame for one triangle from the two held corners and the closing vertex
	function automatic frame_t triangle_frame(input vtx_t c2);
		logic signed [63:0] pd [6];
		logic signed [63:0] td [4];
		logic signed [63:0] e1 [3], e2 [3], t [3], b [3], n [3];
		logic signed [63:0] p [3];
		logic signed [63:0] det, sgn;
		logic signed [15:0] ut [3], ub [3], un [3];
		logic [63:0]        acc;
		int                 sp, st;
		bit                 ok;
		frame_t             f;
		p[0] = c2.pos_x;
		p[1] = c2.pos_y;
		p[2] = c2.pos_z;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			pd[i] = held_pos[3 + i] - held_pos[i];
			pd[3 + i] = p[i] - held_pos[i];
			acc |= magnitude(pd[i]) | magnitude(pd[3 + i]);
		end
		sp = fit_amount(acc);
		for (int i = 0; i < 3; i++) begin
			e1[i] = shift_toward_zero(pd[i], sp);
			e2[i] = shift_toward_zero(pd[3 + i], sp);
		end
		td[0] = held_tex[2] - held_tex[0];
		td[1] = held_tex[3] - held_tex[1];
		td[2] = 64'(signed'(c2.tex_u)) - held_tex[0];
		td[3] = 64'(signed'(c2.tex_v)) - held_tex[1];
		acc = 0;
		for (int i = 0; i < 4; i++)
			acc |= magnitude(td[i]);
		st = fit_amount(acc);
		for (int i = 0; i < 4; i++)
			td[i] = shift_toward_zero(td[i], st);
		det = td[0] * td[3] - td[2] * td[1];
		sgn = (det < 0) ? -64'sd1 : 64'sd1;
		ok = (det != 0);
		for (int i = 0; i < 3; i++) begin
			t[i] = sgn * (td[3] * e1[i] - td[1] * e2[i]);
			b[i] = sgn * (td[0] * e2[i] - td[2] * e1[i]);
		end
		if (ok)
			ok = unitize(t, ut);
		if (ok)
			ok = unitize(b, ub);
		if (ok) begin
			n[0] = 64'(ut[1]) * 64'(ub[2]) - 64'(ut[2]) * 64'(ub[1]);
			n[1] = 64'(ut[2]) * 64'(ub[0]) - 64'(ut[0]) * 64'(ub[2]);
			n[2] = 64'(ut[0]) * 64'(ub[1]) - 64'(ut[1]) * 64'(ub[0]);
			ok = unitize(n, un);
		end
		f = '0;
		if (ok) begin
			f.tangent_x = ut[0]; f.tangent_y = ut[1]; f.tangent_z = ut[2];
			f.binormal_x = ub[0]; f.binormal_y = ub[1]; f.binormal_z = ub[2];
			f.normal_x = un[0]; f.normal_y = un[1]; f.normal_z = un[2];
		end
		f.degenerate = !ok;
		return f;
	endfunction

	assign pending = exp_wr - exp_rd;

	// Vertex side: hold corners, predict on the third
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_cnt <= '0;
			exp_wr     <= 0;
		end else if (vtx.valid && vtx.ready) begin
			if (corner_cnt < 2) begin
				held_pos[corner_cnt[0] * 3 + 0] = vtx.item.pos_x;
				held_pos[corner_cnt[0] * 3 + 1] = vtx.item.pos_y;
				held_pos[corner_cnt[0] * 3 + 2] = vtx.item.pos_z;
				held_tex[corner_cnt[0] * 2 + 0] = vtx.item.tex_u;
				held_tex[corner_cnt[0] * 2 + 1] = vtx.item.tex_v;
				corner_cnt <= corner_cnt + 2'd1;
			end else begin
				exp_mem[exp_wr % EXP_DEPTH] <= triangle_frame(vtx.item);
				exp_wr     <= exp_wr + 1;
				corner_cnt <= '0;
			end
		end
	end

	// Frame side: compare with the oldest expected frame
	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			fail_count  <= 0;
			frames_seen <= 0;
			degen_seen  <= 0;
			exp_rd      <= 0;
		end else if (frame.valid && frame.ready) begin
			frames_seen <= frames_seen + 1;
			degen_seen  <= degen_seen + frame.item.degenerate;
			if (exp_wr == exp_rd) begin
				if (fail_count < 10)
					$display("%0t: frame item with none expected: %p", $realtime, frame.item);
				fail_count <= fail_count + 1;
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd <= exp_rd + 1;
				if (want !== frame.item) begin
					if (fail_count < 10)
						$display("%0t: frame mismatch\n  expected %p\n  actual   %p",
							$realtime, want, frame.item);
					fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

// ----- bench/tb_triangle_tangent_frame.sv -----
// Testbench top: vertex stimulus, frame sink stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_triangle_tangent_frame;
	import ttf_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_TRIS = 143;

	logic clk;
	logic arst_n;
	int   fail_count, pending, frames_seen, degen_seen;
	int   vertices_sent;
	int   idle_cycles;

	ttf_vtx_if   vtx ();
	ttf_frame_if frame ();

	triangle_tangent_frame dut (.clk(clk), .arst_n(arst_n), .vtx(vtx), .frame(frame));

	tb_frame_checker checker_i (
		.clk(clk), .arst_n(arst_n), .vtx(vtx), .frame(frame),
		.fail_count(fail_count), .pending(pending),
		.frames_seen(frames_seen), .degen_seen(degen_seen)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
			default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
		endcase
	endfunction

	// Send one vertex, with a random gap before it; valid stays high when no gap follows
	task automatic send_vertex(input logic [31:0] px, py, pz, tu, tv);
		int g;
		g = gap_len();
		if ($urandom_range(0, 3) == 0)
			g = 0;
		if (g > 0) begin
			vtx.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.item  <= '{px, py, pz, tu, tv};
		// ready only moves after a rising edge, so look at it in the low phase
		@(negedge clk);
		while (!vtx.ready)
			@(negedge clk);
		@(posedge clk);
		vertices_sent++;
	endtask

	task automatic send_random_tri();
		logic [31:0] c [15];
		for (int i = 0; i < 15; i++)
			c[i] = rand_coord();
		// some triangles share texture coordinates: zero determinant
		if ($urandom_range(0, 9) == 0) begin
			c[8] = c[3]; c[9] = c[4];
		end
		// some triangles collapse to a point: zero length
		if ($urandom_range(0, 14) == 0) begin
			c[5] = c[0]; c[6] = c[1]; c[7] = c[2];
			c[10] = c[0]; c[11] = c[1]; c[12] = c[2];
		end
		for (int k = 0; k < 3; k++)
			send_vertex(c[k*5], c[k*5+1], c[k*5+2], c[k*5+3], c[k*5+4]);
	endtask

	// Receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame.ready <= 1'b0;
		else
			frame.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
	end

	// Watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if (!arst_n || (vtx.valid && vtx.ready) || (frame.valid && frame.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		vtx.valid     = 1'b0;
		vtx.item      = '0;
		vertices_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain right triangle
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h0001_0000, 0, 0, 32'h0001_0000, 0);
		send_vertex(0, 32'h0001_0000, 0, 0, 32'h0001_0000);
		// mirrored texture: negative determinant
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h0001_0000, 0, 0, 0, 32'h0001_0000);
		send_vertex(0, 32'h0001_0000, 0, 32'h0001_0000, 0);
		// field extremes: widest deltas
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		// equal texture coordinates: zero determinant
		send_vertex(1, 2, 3, 5, 5);
		send_vertex(4, 5, 6, 5, 5);
		send_vertex(7, 9, 8, 5, 5);
		// all corners at one point: zero length
		send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h10, 0);
		send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h10);
		// collinear corners: tangent and binormal parallel, zero normal
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h0002_0000, 0, 0, 32'h0001_0000, 0);
		send_vertex(32'h0004_0000, 0, 0, 0, 32'h0001_0000);
		// tiny deltas
		send_vertex(32'hFFFF_FFFF, 0, 1, 0, 0);
		send_vertex(0, 1, 0, 1, 0);
		send_vertex(1, 0, 32'hFFFF_FFFF, 0, 1);

		// hold off until every expected frame has arrived
		vtx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		for (int t = 0; t < RANDOM_TRIS; t++)
			send_random_tri();

		vtx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Covered %0d vertices, %0d frames (%0d degenerate).",
			vertices_sent, frames_seen, degen_seen);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/ttf_pkg.sv
rtl/core/ttf_if.sv
rtl/core/ttf_iter.sv
rtl/core/ttf_dp.sv
rtl/core/ttf_ctrl.sv
rtl/core/triangle_tangent_frame.sv
bench/tb_frame_checker.sv
bench/tb_triangle_tangent_frame.sv
